### design/qrm_pkg.sv
// shared constants and stage types for the quaternion to rotation matrix pipeline
package qrm_pkg;

  localparam int FRACTION_BITS = 14;
  localparam int IN_W          = 16;
  localparam int OUT_W         = 16;
  localparam int NUM_ENT       = 9;
  localparam int PROD_W        = 2 * IN_W;
  localparam int NORM_W        = PROD_W + 1;
  localparam int NUM_W         = PROD_W + 2;
  localparam int QUO_W         = FRACTION_BITS + 1;

  // squares and cross products of the quaternion components
  typedef struct packed {
    logic [PROD_W-1:0] ww;
    logic [PROD_W-1:0] xx;
    logic [PROD_W-1:0] yy;
    logic [PROD_W-1:0] zz;
    logic [PROD_W-1:0] xy;
    logic [PROD_W-1:0] zw;
    logic [PROD_W-1:0] xz;
    logic [PROD_W-1:0] yw;
    logic [PROD_W-1:0] yz;
    logic [PROD_W-1:0] xw;
  } qrm_prod_t;

  // squared norm and signed numerators, row-major order
  typedef struct packed {
    logic [NORM_W-1:0]             norm;
    logic [NUM_ENT-1:0][NUM_W-1:0] num;
  } qrm_num_t;

  // squared norm, numerator magnitudes and signs
  typedef struct packed {
    logic [NORM_W-1:0]             norm;
    logic [NUM_ENT-1:0][NUM_W-1:0] mag;
    logic [NUM_ENT-1:0]            neg;
    logic                          zero;
  } qrm_mag_t;

  // one step of the long division, all nine entries side by side
  typedef struct packed {
    logic [NORM_W-1:0]              n;
    logic [NUM_ENT-1:0][NORM_W-1:0] rem;
    logic [NUM_ENT-1:0][QUO_W-1:0]  q;
    logic [NUM_ENT-1:0]             neg;
    logic                           zero;
  } qrm_div_t;

  typedef struct packed {
    logic [NUM_ENT-1:0][OUT_W-1:0] ent;
    logic                          zero;
  } qrm_out_t;

endpackage

### design/quaternion_to_rotation_matrix.sv
// quaternion to 3x3 rotation matrix, fully pipelined with normalizing division
//
// Converts one quaternion (w, x, y, z, signed Q2.14) into the nine entries of its
// rotation matrix (signed Q2.14, row-major), each divided by the squared norm,
// truncated toward zero and limited to +/-1.0. A new request is taken every cycle
// while stall_o is low. The stages, in order: one stage of ten 16x16
// multipliers, one for the norm and numerators, one for magnitudes, one for the
// leading quotient bit, then one restoring-division stage per fraction bit with
// nine dividers side by side, then the output register. Each stage moves on its
// own, so bubbles close up and requests are still taken while a result waits.
// An all-zero quaternion gives zero_norm_o and all-zero entries.
module quaternion_to_rotation_matrix
  import qrm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    stall_o,
  input  logic signed [IN_W-1:0]  quat_w_i,
  input  logic signed [IN_W-1:0]  quat_x_i,
  input  logic signed [IN_W-1:0]  quat_y_i,
  input  logic signed [IN_W-1:0]  quat_z_i,
  output logic                    valid_o,
  input  logic                    stall_i,
  output logic signed [OUT_W-1:0] row0_col0_o,
  output logic signed [OUT_W-1:0] row0_col1_o,
  output logic signed [OUT_W-1:0] row0_col2_o,
  output logic signed [OUT_W-1:0] row1_col0_o,
  output logic signed [OUT_W-1:0] row1_col1_o,
  output logic signed [OUT_W-1:0] row1_col2_o,
  output logic signed [OUT_W-1:0] row2_col0_o,
  output logic signed [OUT_W-1:0] row2_col1_o,
  output logic signed [OUT_W-1:0] row2_col2_o,
  output logic                    zero_norm_o
);

  localparam int LAST = FRACTION_BITS;

  // one restoring step: shift the remainder, subtract the norm if it fits
  function automatic logic [NORM_W:0] div_step(input logic [NORM_W-1:0] rem,
                                              input logic [NORM_W-1:0] n);
    logic [NORM_W:0] r2;
    logic [NORM_W:0] diff;
    logic            ge;
    r2   = {rem, 1'b0};
    diff = r2 - {1'b0, n};
    ge   = (r2 >= {1'b0, n});
    return ge ? {NORM_W'(diff), 1'b1} : {NORM_W'(r2), 1'b0};
  endfunction

  function automatic logic [OUT_W-1:0] apply_sign(input logic [QUO_W-1:0] q,
                                                  input logic neg);
    logic signed [QUO_W:0] v;
    v = $signed({1'b0, q});
    if (neg) begin
      v = -v;
    end
    return OUT_W'(v);
  endfunction

  // stage registers
  logic      mul_v_q, num_v_q, mag_v_q, valid_o_q;
  qrm_prod_t mul_q;
  qrm_num_t  num_q, num_d;
  qrm_mag_t  mag_q, mag_d;
  qrm_div_t  div_q [LAST+1];
  qrm_div_t  div_d [LAST+1];
  logic [LAST:0] dv_q;
  qrm_out_t  out_q, out_d;

  logic mul_rdy, num_rdy, mag_rdy, out_rdy;
  logic [LAST:0] div_rdy;

  // each stage loads when it is empty or its successor loads
  assign out_rdy = !valid_o_q || !stall_i;
  assign div_rdy[LAST] = !dv_q[LAST] || out_rdy;
  for (genvar k = 0; k < LAST; k++) begin : g_rdy
    assign div_rdy[k] = !dv_q[k] || div_rdy[k+1];
  end
  assign mag_rdy = !mag_v_q || div_rdy[0];
  assign num_rdy = !num_v_q || mag_rdy;
  assign mul_rdy = !mul_v_q || num_rdy;
  assign stall_o = !mul_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q   <= 1'b0;
      num_v_q   <= 1'b0;
      mag_v_q   <= 1'b0;
      dv_q      <= '0;
      valid_o_q <= 1'b0;
    end else begin
      if (mul_rdy) mul_v_q <= valid_i;
      if (num_rdy) num_v_q <= mul_v_q;
      if (mag_rdy) mag_v_q <= num_v_q;
      if (div_rdy[0]) dv_q[0] <= mag_v_q;
      for (int k = 1; k <= LAST; k++) begin
        if (div_rdy[k]) dv_q[k] <= dv_q[k-1];
      end
      if (out_rdy) valid_o_q <= dv_q[LAST];
    end
  end

  // stage 1: products
  always_ff @(posedge clk_i) begin
    if (mul_rdy) begin
      mul_q.ww <= PROD_W'(quat_w_i * quat_w_i);
      mul_q.xx <= PROD_W'(quat_x_i * quat_x_i);
      mul_q.yy <= PROD_W'(quat_y_i * quat_y_i);
      mul_q.zz <= PROD_W'(quat_z_i * quat_z_i);
      mul_q.xy <= PROD_W'(quat_x_i * quat_y_i);
      mul_q.zw <= PROD_W'(quat_z_i * quat_w_i);
      mul_q.xz <= PROD_W'(quat_x_i * quat_z_i);
      mul_q.yw <= PROD_W'(quat_y_i * quat_w_i);
      mul_q.yz <= PROD_W'(quat_y_i * quat_z_i);
      mul_q.xw <= PROD_W'(quat_x_i * quat_w_i);
    end
  end

  // stage 2: squared norm and numerators
  always_comb begin
    logic signed [NUM_W-1:0] ww, xx, yy, zz, xy, zw, xz, yw, yz, xw;
    ww = NUM_W'($signed(mul_q.ww));
    xx = NUM_W'($signed(mul_q.xx));
    yy = NUM_W'($signed(mul_q.yy));
    zz = NUM_W'($signed(mul_q.zz));
    xy = NUM_W'($signed(mul_q.xy));
    zw = NUM_W'($signed(mul_q.zw));
    xz = NUM_W'($signed(mul_q.xz));
    yw = NUM_W'($signed(mul_q.yw));
    yz = NUM_W'($signed(mul_q.yz));
    xw = NUM_W'($signed(mul_q.xw));
    num_d.norm   = NORM_W'(mul_q.ww) + NORM_W'(mul_q.xx)
                 + NORM_W'(mul_q.yy) + NORM_W'(mul_q.zz);
    num_d.num[0] = xx - yy - zz + ww;
    num_d.num[1] = (xy - zw) <<< 1;
    num_d.num[2] = (xz + yw) <<< 1;
    num_d.num[3] = (xy + zw) <<< 1;
    num_d.num[4] = yy - xx - zz + ww;
    num_d.num[5] = (yz - xw) <<< 1;
    num_d.num[6] = (xz - yw) <<< 1;
    num_d.num[7] = (yz + xw) <<< 1;
    num_d.num[8] = zz - xx - yy + ww;
  end

  always_ff @(posedge clk_i) begin
    if (num_rdy) num_q <= num_d;
  end

  // stage 3: magnitudes and signs
  always_comb begin
    mag_d.norm = num_q.norm;
    mag_d.zero = (num_q.norm == '0);
    for (int i = 0; i < NUM_ENT; i++) begin
      mag_d.neg[i] = num_q.num[i][NUM_W-1];
      mag_d.mag[i] = num_q.num[i][NUM_W-1] ? NUM_W'(-num_q.num[i]) : num_q.num[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mag_rdy) mag_q <= mag_d;
  end

  // stage 4: leading quotient bit, magnitude at or above the norm saturates
  always_comb begin
    div_d[0].n    = mag_q.norm;
    div_d[0].neg  = mag_q.neg;
    div_d[0].zero = mag_q.zero;
    for (int i = 0; i < NUM_ENT; i++) begin
      if (mag_q.mag[i] >= NUM_W'(mag_q.norm)) begin
        div_d[0].q[i]   = QUO_W'(1);
        div_d[0].rem[i] = '0;
      end else begin
        div_d[0].q[i]   = '0;
        div_d[0].rem[i] = NORM_W'(mag_q.mag[i]);
      end
    end
  end

  // division stages, one quotient bit each
  for (genvar k = 1; k <= LAST; k++) begin : g_div
    always_comb begin
      logic [NORM_W:0] step;
      div_d[k].n    = div_q[k-1].n;
      div_d[k].neg  = div_q[k-1].neg;
      div_d[k].zero = div_q[k-1].zero;
      for (int i = 0; i < NUM_ENT; i++) begin
        step            = div_step(div_q[k-1].rem[i], div_q[k-1].n);
        div_d[k].rem[i] = step[NORM_W:1];
        div_d[k].q[i]   = {div_q[k-1].q[i][QUO_W-2:0], step[0]};
      end
    end
  end

  for (genvar k = 0; k <= LAST; k++) begin : g_div_reg
    always_ff @(posedge clk_i) begin
      if (div_rdy[k]) div_q[k] <= div_d[k];
    end
  end

  // output stage: sign, zero-norm override
  always_comb begin
    out_d.zero = div_q[LAST].zero;
    for (int i = 0; i < NUM_ENT; i++) begin
      out_d.ent[i] = div_q[LAST].zero ? '0
                                      : apply_sign(div_q[LAST].q[i], div_q[LAST].neg[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy) out_q <= out_d;
  end

  assign valid_o     = valid_o_q;
  assign row0_col0_o = out_q.ent[0];
  assign row0_col1_o = out_q.ent[1];
  assign row0_col2_o = out_q.ent[2];
  assign row1_col0_o = out_q.ent[3];
  assign row1_col1_o = out_q.ent[4];
  assign row1_col2_o = out_q.ent[5];
  assign row2_col0_o = out_q.ent[6];
  assign row2_col1_o = out_q.ent[7];
  assign row2_col2_o = out_q.ent[8];
  assign zero_norm_o = out_q.zero;

  // input is held off only when every stage is full and the output is stalled
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i && (&dv_q) && mul_v_q && num_v_q && mag_v_q))
    else $error("input stalled with a free pipeline stage");

  // zero-norm results carry all-zero entries
  a_zero_entries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && zero_norm_o) |-> (out_q.ent == '0))
    else $error("zero-norm result with nonzero entries");

  // remainder of entries 0 and 8 is below the divisor at the last division stage
  a_rem_below_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_q[LAST] && !div_q[LAST].zero) |->
      (div_q[LAST].rem[0] < div_q[LAST].n && div_q[LAST].rem[8] < div_q[LAST].n))
    else $error("division remainder not below norm");

  // a blocked last division stage keeps its item
  a_div_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_q[LAST] && !div_rdy[LAST]) |=> (dv_q[LAST] && $stable(div_q[LAST].q)))
    else $error("stalled division stage lost its item");

endmodule
